// ===== sv/triangle_rasterizer_depth_test_assert.svh =====
// Assertion macros shared by the rasterizer modules.
`ifndef TRIANGLE_RASTERIZER_DEPTH_TEST_ASSERT_SVH
`define TRIANGLE_RASTERIZER_DEPTH_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`endif

// ===== sv/trdt_pkg.sv =====
// Shared constants, types and command codes of the triangle rasterizer.
package trdt_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int SUBPIXEL_BITS     = 4;
    localparam int DEPTH_BITS        = 16;

    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 24;
    localparam int OPCODE_W = 3;
    localparam int RIDX_W   = 12;
    localparam int WCOUNT_W = 13;

    // Pixel counters cover the largest screen and the largest vertex column.
    localparam int PIX_CW  = 11;
    localparam int PT_W    = PIX_CW + SUBPIXEL_BITS;
    localparam int DIFF_W  = PT_W + 1;
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = DELTA_W + DIFF_W;
    localparam int EDGE_W  = PROD_W + 1;
    localparam int SUM_W   = EDGE_W + 2;
    localparam int WZ_W    = EDGE_W + DEPTH_BITS;
    localparam int NUM_W   = WZ_W + 2;
    localparam int DVD_W   = NUM_W + 1;
    localparam int QUO_W   = DEPTH_BITS + 1;

    localparam logic [OPCODE_W-1:0] OP_DRAW        = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READ        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_COLOR = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_DEPTH = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_BOTH  = 3'd4;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_DRAW,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                        kind;
        logic                             ms;
        logic                             clr_color;
        logic                             clr_depth;
        logic [2:0][COORD_W-1:0]          vx;
        logic [2:0][COORD_W-1:0]          vy;
        logic [2:0][DEPTH_BITS-1:0]       vz;
        logic [COLOR_W-1:0]               color;
        logic [RIDX_W-1:0]                read_index;
        logic [PIX_CW-1:0]                xlo;
        logic [PIX_CW-1:0]                xhi;
        logic [PIX_CW-1:0]                ylo;
        logic [PIX_CW-1:0]                yhi;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic init_clear;
    } back_stat_t;

endpackage

// ===== sv/triangle_rasterizer_depth_test.sv =====
// Top level of the triangle rasterizer with depth test and 2x2 multisampling.
//
//   Channel   Ports                                   Handshake
//   -------   -------------------------------------   ----------------------------
//   command   opcode, vert*_x/y/z, tri_color,         beat taken when start is high
//             read_index                              and busy is low
//   result    pixel_color, pixel_depth,               beat shown for one cycle with
//             pixels_written                          done high, never held off
//   config    cfg_data (multisample_enable)           beat taken on cfg_valid and
//                                                     cfg_ready, ready always high
//
// After reset both stores are swept, one entry a cycle, over all SCREEN_WIDTH *
// SCREEN_HEIGHT entries (4096 by default); busy stays high through the sweep.
// A command beat enters a short queue; the pixel engine then takes each command
// in order. A read passes through ST_READ and ST_READ_OUT before its result beat;
// a clear sweeps every entry, one entry a cycle. A draw runs ST_SETUP, then for
// each bounding box pixel the states ST_SMUL, ST_SEDGE, ST_SWZ and ST_SNUM per
// sample (four samples in 2x2 mode, one otherwise) and, for a pixel with a
// covered sample, the depth divide on the bit-serial divider. After the sweep,
// busy rises only while the queue is full.
// The receiver cannot stall: every result beat lasts exactly one cycle.
module triangle_rasterizer_depth_test #(
    parameter int SCREEN_WIDTH  = trdt_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = trdt_pkg::SCREEN_HEIGHT_DEF,
    parameter int QUEUE_DEPTH   = trdt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [trdt_pkg::OPCODE_W-1:0]      opcode,
    input  logic [trdt_pkg::COORD_W-1:0]       vert0_x,
    input  logic [trdt_pkg::COORD_W-1:0]       vert0_y,
    input  logic [trdt_pkg::DEPTH_BITS-1:0]    vert0_z,
    input  logic [trdt_pkg::COORD_W-1:0]       vert1_x,
    input  logic [trdt_pkg::COORD_W-1:0]       vert1_y,
    input  logic [trdt_pkg::DEPTH_BITS-1:0]    vert1_z,
    input  logic [trdt_pkg::COORD_W-1:0]       vert2_x,
    input  logic [trdt_pkg::COORD_W-1:0]       vert2_y,
    input  logic [trdt_pkg::DEPTH_BITS-1:0]    vert2_z,
    input  logic [trdt_pkg::COLOR_W-1:0]       tri_color,
    input  logic [trdt_pkg::RIDX_W-1:0]        read_index,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,
    output logic                               done,
    output logic [trdt_pkg::COLOR_W-1:0]       pixel_color,
    output logic [trdt_pkg::DEPTH_BITS-1:0]    pixel_depth,
    output logic [trdt_pkg::WCOUNT_W-1:0]      pixels_written
);
    import trdt_pkg::*;

    q_stat_t    q_stat;
    back_stat_t back_stat;
    cmd_t       push_entry;
    cmd_t       head;
    logic       push;
    logic       pop;

    // The front end decodes each command beat and clips its bounding box.
    trdt_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .vx         ({vert2_x, vert1_x, vert0_x}),
        .vy         ({vert2_y, vert1_y, vert0_y}),
        .vz         ({vert2_z, vert1_z, vert0_z}),
        .tri_color  (tri_color),
        .read_index (read_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .back_stat  (back_stat),
        .push       (push),
        .entry      (push_entry)
    );

    // Decoded commands wait here while the engine works on earlier ones.
    trdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    // The engine owns both stores and produces every result beat.
    trdt_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_stat         (q_stat),
        .pop            (pop),
        .back_stat      (back_stat),
        .done           (done),
        .pixel_color    (pixel_color),
        .pixel_depth    (pixel_depth),
        .pixels_written (pixels_written)
    );

endmodule

// ===== sv/trdt_front.sv =====
// Command front end: accepts beats, decodes opcodes and sets up bounding boxes.
module trdt_front #(
    parameter int SCREEN_WIDTH  = trdt_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = trdt_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [trdt_pkg::OPCODE_W-1:0]      opcode,
    input  logic [2:0][trdt_pkg::COORD_W-1:0]  vx,
    input  logic [2:0][trdt_pkg::COORD_W-1:0]  vy,
    input  logic [2:0][trdt_pkg::DEPTH_BITS-1:0] vz,
    input  logic [trdt_pkg::COLOR_W-1:0]       tri_color,
    input  logic [trdt_pkg::RIDX_W-1:0]        read_index,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,
    input  trdt_pkg::q_stat_t                  q_stat,
    input  trdt_pkg::back_stat_t               back_stat,
    output logic                               push,
    output trdt_pkg::cmd_t                     entry
);
    import trdt_pkg::*;

    logic               ms_reg;
    logic               ms_next;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic [PIX_CW-1:0]  xhi_raw;
    logic [PIX_CW-1:0]  yhi_raw;

    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full | back_stat.init_clear;
    assign push      = start & ~busy;

    always_comb
    begin
        ms_next = ms_reg;
        if (cfg_valid && cfg_ready)
        begin
            ms_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg <= 1'b1;
        end
        else
        begin
            ms_reg <= ms_next;
        end
    end

    always_comb
    begin
        min_x = vx[0];
        max_x = vx[0];
        min_y = vy[0];
        max_y = vy[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx[i] < min_x) min_x = vx[i];
            if (vx[i] > max_x) max_x = vx[i];
            if (vy[i] < min_y) min_y = vy[i];
            if (vy[i] > max_y) max_y = vy[i];
        end
        xhi_raw = PIX_CW'(max_x >> SUBPIXEL_BITS) + PIX_CW'(1);
        yhi_raw = PIX_CW'(max_y >> SUBPIXEL_BITS) + PIX_CW'(1);
    end

    always_comb
    begin
        entry            = '0;
        entry.ms         = ms_reg;
        entry.vx         = vx;
        entry.vy         = vy;
        entry.vz         = vz;
        entry.color      = tri_color;
        entry.read_index = read_index;
        entry.xlo        = PIX_CW'(min_x >> SUBPIXEL_BITS);
        entry.ylo        = PIX_CW'(min_y >> SUBPIXEL_BITS);
        entry.xhi        = (xhi_raw > PIX_CW'(SCREEN_WIDTH - 1))
                           ? PIX_CW'(SCREEN_WIDTH - 1) : xhi_raw;
        entry.yhi        = (yhi_raw > PIX_CW'(SCREEN_HEIGHT - 1))
                           ? PIX_CW'(SCREEN_HEIGHT - 1) : yhi_raw;
        unique case (opcode)
            OP_DRAW:
            begin
                entry.kind = CMD_DRAW;
            end
            OP_READ:
            begin
                entry.kind = CMD_READ;
            end
            OP_CLEAR_COLOR:
            begin
                entry.kind      = CMD_CLEAR;
                entry.clr_color = 1'b1;
            end
            OP_CLEAR_DEPTH:
            begin
                entry.kind      = CMD_CLEAR;
                entry.clr_depth = 1'b1;
            end
            OP_CLEAR_BOTH:
            begin
                entry.kind      = CMD_CLEAR;
                entry.clr_color = 1'b1;
                entry.clr_depth = 1'b1;
            end
            default:
            begin
                entry.kind = CMD_NOP;
            end
        endcase
    end

endmodule

// ===== sv/trdt_queue.sv =====
// Short command queue between the front end and the pixel engine.
`include "triangle_rasterizer_depth_test_assert.svh"

module trdt_queue #(
    parameter int DEPTH = trdt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  trdt_pkg::cmd_t    push_entry,
    input  logic              pop,
    output trdt_pkg::cmd_t    head,
    output trdt_pkg::q_stat_t q_stat
);
    import trdt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `TRDT_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !q_stat.full)
    `TRDT_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty)
    `TRDT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

// ===== sv/trdt_div.sv =====
// Restoring divider that gives one quotient bit per cycle.
module trdt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [trdt_pkg::DVD_W-1:0]    dividend,
    input  logic [trdt_pkg::SUM_W-1:0]    divisor,
    output logic                          busy,
    output logic                          done,
    output logic [trdt_pkg::QUO_W-1:0]    quotient
);
    import trdt_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [SUM_W-1:0] div_reg;
    logic [SUM_W-1:0] div_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, div_reg};
        if (start)
        begin
            // The quotient fits QUO_W bits, so the top part starts below the divisor.
            rem_next  = dividend[DVD_W-1:QUO_W];
            quo_next  = dividend[QUO_W-1:0];
            div_next  = divisor;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[SUM_W])
            begin
                rem_next = diff[SUM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

// ===== sv/trdt_back.sv =====
// Pixel engine: walks draws sample by sample, serves reads and sweeps clears.
`include "triangle_rasterizer_depth_test_assert.svh"

module trdt_back #(
    parameter int SCREEN_WIDTH  = trdt_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = trdt_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  trdt_pkg::cmd_t                    head,
    input  trdt_pkg::q_stat_t                 q_stat,
    output logic                              pop,
    output trdt_pkg::back_stat_t              back_stat,
    output logic                              done,
    output logic [trdt_pkg::COLOR_W-1:0]      pixel_color,
    output logic [trdt_pkg::DEPTH_BITS-1:0]   pixel_depth,
    output logic [trdt_pkg::WCOUNT_W-1:0]     pixels_written
);
    import trdt_pkg::*;

    localparam int PIX_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int IDX_W     = $clog2(PIX_COUNT);
    localparam int ROW_MAX   = SCREEN_HEIGHT - 1;
    localparam int SUB_ONE   = 1 << SUBPIXEL_BITS;
    localparam int OFF_LO    = SUB_ONE / 4;
    localparam int OFF_HI    = SUB_ONE / 4 + SUB_ONE / 2;
    localparam int OFF_MID   = SUB_ONE / 2;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_READ_OUT,
        ST_NOP_OUT,
        ST_SETUP,
        ST_SMUL,
        ST_SEDGE,
        ST_SWZ,
        ST_SNUM,
        ST_DIVGO,
        ST_DIV,
        ST_DRAW_OUT
    } state_t;

    // Control state.
    state_t                state_reg, state_next;
    logic                  clr_color_reg, clr_color_next;
    logic                  clr_depth_reg, clr_depth_next;
    logic                  report_reg, report_next;
    logic                  init_clear_reg, init_clear_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [PIX_CW-1:0]     px_reg, px_next;
    logic [PIX_CW-1:0]     py_reg, py_next;
    logic [1:0]            samp_reg, samp_next;
    logic [2:0]            k_reg, k_next;
    logic                  have_reg, have_next;
    logic [WCOUNT_W-1:0]   written_reg, written_next;
    logic                  done_reg, done_next;
    logic [COLOR_W-1:0]    color_out_reg, color_out_next;
    logic [DEPTH_BITS-1:0] depth_out_reg, depth_out_next;
    logic [WCOUNT_W-1:0]   wcount_out_reg, wcount_out_next;

    // Datapath registers.
    cmd_t                     cur_reg, cur_next;
    logic                     in_range_reg, in_range_next;
    logic signed [DELTA_W-1:0] ex_reg [3];
    logic signed [DELTA_W-1:0] ex_next [3];
    logic signed [DELTA_W-1:0] ey_reg [3];
    logic signed [DELTA_W-1:0] ey_next [3];
    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pa_c [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    logic signed [PROD_W-1:0] pb_c [3];
    logic signed [EDGE_W-1:0] e_reg [3];
    logic signed [EDGE_W-1:0] e_c [3];
    logic [WZ_W-1:0]          wz_reg [3];
    logic [WZ_W-1:0]          wz_c [3];
    logic                     cov_reg, cov_c;
    logic [SUM_W-1:0]         wsum_reg, wsum_c;
    logic [NUM_W-1:0]         best_num_reg, best_num_next;
    logic [SUM_W-1:0]         best_sum_reg, best_sum_next;

    // Combinational helpers.
    logic [PT_W-1:0]          off_x, off_y, sx_pt, sy_pt;
    logic signed [DIFF_W-1:0] dx [3];
    logic signed [DIFF_W-1:0] dy [3];
    logic [EDGE_W-1:0]        mag [3];
    logic                     all_pos, all_neg;
    logic [NUM_W-1:0]         num_c;
    logic [2:0]               k_inc;
    logic                     last_samp;
    logic                     advance;
    logic [IDX_W-1:0]         pix_idx;
    logic [DEPTH_BITS-1:0]    z_c;
    logic [COLOR_W-1:0]       shade_c;
    logic [10:0]              chan_prod [3];

    // Memory ports.
    logic [COLOR_W-1:0]    color_mem [PIX_COUNT];
    logic [DEPTH_BITS-1:0] depth_mem [PIX_COUNT];
    logic                  wr_color_en, wr_depth_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [COLOR_W-1:0]    wr_color_data;
    logic [DEPTH_BITS-1:0] wr_depth_data;
    logic [COLOR_W-1:0]    rd_color_reg;
    logic [DEPTH_BITS-1:0] rd_depth_reg;

    // Divider.
    logic                  div_start, div_busy, div_done;
    logic [DVD_W-1:0]      div_dividend;
    logic [QUO_W-1:0]      div_quo;

    assign done                 = done_reg;
    assign pixel_color          = color_out_reg;
    assign pixel_depth          = depth_out_reg;
    assign pixels_written       = wcount_out_reg;
    assign back_stat.init_clear = init_clear_reg;

    assign div_dividend = DVD_W'(best_num_reg) + DVD_W'(best_sum_reg >> 1);

    trdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (best_sum_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sample arithmetic, one stage of it per state.
    always_comb
    begin
        if (cur_reg.ms)
        begin
            off_x = samp_reg[0] ? PT_W'(OFF_HI) : PT_W'(OFF_LO);
            off_y = samp_reg[1] ? PT_W'(OFF_HI) : PT_W'(OFF_LO);
        end
        else
        begin
            off_x = PT_W'(OFF_MID);
            off_y = PT_W'(OFF_MID);
        end
        sx_pt = {px_reg, {SUBPIXEL_BITS{1'b0}}} + off_x;
        sy_pt = {py_reg, {SUBPIXEL_BITS{1'b0}}} + off_y;
        for (int i = 0; i < 3; i++)
        begin
            dx[i]   = $signed({1'b0, sx_pt}) - $signed(DIFF_W'(cur_reg.vx[i]));
            dy[i]   = $signed({1'b0, sy_pt}) - $signed(DIFF_W'(cur_reg.vy[i]));
            pa_c[i] = PROD_W'(ex_reg[i]) * PROD_W'(dy[i]);
            pb_c[i] = PROD_W'(ey_reg[i]) * PROD_W'(dx[i]);
            e_c[i]  = EDGE_W'(pa_reg[i]) - EDGE_W'(pb_reg[i]);
            mag[i]  = e_reg[i][EDGE_W-1] ? EDGE_W'(-e_reg[i]) : EDGE_W'(e_reg[i]);
        end
        all_pos = !e_reg[0][EDGE_W-1] && (e_reg[0] != '0)
               && !e_reg[1][EDGE_W-1] && (e_reg[1] != '0)
               && !e_reg[2][EDGE_W-1] && (e_reg[2] != '0);
        all_neg = e_reg[0][EDGE_W-1] && e_reg[1][EDGE_W-1] && e_reg[2][EDGE_W-1];
        cov_c   = all_pos | all_neg;
        // Vertex weight j comes from the edge opposite to vertex j.
        wz_c[0] = WZ_W'(mag[1]) * WZ_W'(cur_reg.vz[0]);
        wz_c[1] = WZ_W'(mag[2]) * WZ_W'(cur_reg.vz[1]);
        wz_c[2] = WZ_W'(mag[0]) * WZ_W'(cur_reg.vz[2]);
        wsum_c  = SUM_W'(mag[0]) + SUM_W'(mag[1]) + SUM_W'(mag[2]);
        num_c   = NUM_W'(wz_reg[0]) + NUM_W'(wz_reg[1]) + NUM_W'(wz_reg[2]);
        k_inc   = k_reg + {2'b00, cov_reg};
        last_samp = cur_reg.ms ? (samp_reg == 2'd3) : 1'b1;
        pix_idx = IDX_W'((ROW_MAX - 32'(py_reg)) * SCREEN_WIDTH + 32'(px_reg));
        z_c     = (div_quo > QUO_W'(DEPTH_MAX)) ? DEPTH_MAX : div_quo[DEPTH_BITS-1:0];
        for (int c = 0; c < 3; c++)
        begin
            chan_prod[c] = 11'(cur_reg.color[8*c +: 8]) * 11'(k_reg);
        end
        if (cur_reg.ms)
        begin
            shade_c = {chan_prod[2][9:2], chan_prod[1][9:2], chan_prod[0][9:2]};
        end
        else
        begin
            shade_c = cur_reg.color;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_color_next  = clr_color_reg;
        clr_depth_next  = clr_depth_reg;
        report_next     = report_reg;
        init_clear_next = init_clear_reg;
        clr_addr_next   = clr_addr_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        samp_next       = samp_reg;
        k_next          = k_reg;
        have_next       = have_reg;
        written_next    = written_reg;
        done_next       = 1'b0;
        color_out_next  = '0;
        depth_out_next  = '0;
        wcount_out_next = '0;
        cur_next        = cur_reg;
        in_range_next   = in_range_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        best_num_next   = best_num_reg;
        best_sum_next   = best_sum_reg;
        pop             = 1'b0;
        div_start       = 1'b0;
        advance         = 1'b0;
        wr_color_en     = 1'b0;
        wr_depth_en     = 1'b0;
        wr_addr         = pix_idx;
        wr_color_data   = shade_c;
        wr_depth_data   = z_c;
        rd_en           = 1'b0;
        rd_addr         = pix_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    unique case (head.kind)
                        CMD_DRAW:  state_next = ST_SETUP;
                        CMD_READ:  state_next = ST_READ;
                        CMD_CLEAR:
                        begin
                            clr_color_next = head.clr_color;
                            clr_depth_next = head.clr_depth;
                            clr_addr_next  = '0;
                            report_next    = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default:   state_next = ST_NOP_OUT;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                wr_addr       = clr_addr_reg;
                wr_color_en   = clr_color_reg;
                wr_depth_en   = clr_depth_reg;
                wr_color_data = '0;
                wr_depth_data = DEPTH_MAX;
                if (clr_addr_reg == IDX_W'(PIX_COUNT - 1))
                begin
                    done_next       = report_reg;
                    init_clear_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end
            ST_READ:
            begin
                in_range_next = (32'(cur_reg.read_index) < 32'(PIX_COUNT));
                rd_en         = 1'b1;
                rd_addr       = IDX_W'(cur_reg.read_index);
                state_next    = ST_READ_OUT;
            end
            ST_READ_OUT:
            begin
                done_next = 1'b1;
                if (in_range_reg)
                begin
                    color_out_next = rd_color_reg;
                    depth_out_next = rd_depth_reg;
                end
                state_next = ST_IDLE;
            end
            ST_NOP_OUT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SETUP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ex_next[i] = $signed(DELTA_W'(cur_reg.vx[(i + 1) % 3]))
                               - $signed(DELTA_W'(cur_reg.vx[i]));
                    ey_next[i] = $signed(DELTA_W'(cur_reg.vy[(i + 1) % 3]))
                               - $signed(DELTA_W'(cur_reg.vy[i]));
                end
                px_next      = cur_reg.xlo;
                py_next      = cur_reg.ylo;
                samp_next    = '0;
                k_next       = '0;
                have_next    = 1'b0;
                written_next = '0;
                if (cur_reg.xlo > cur_reg.xhi || cur_reg.ylo > cur_reg.yhi)
                begin
                    state_next = ST_DRAW_OUT;
                end
                else
                begin
                    state_next = ST_SMUL;
                end
            end
            ST_SMUL:  state_next = ST_SEDGE;
            ST_SEDGE: state_next = ST_SWZ;
            ST_SWZ:   state_next = ST_SNUM;
            ST_SNUM:
            begin
                k_next = k_inc;
                // All covered samples share one weight sum, so the smallest
                // numerator gives the smallest depth.
                if (cov_reg && (!have_reg || num_c < best_num_reg))
                begin
                    best_num_next = num_c;
                    best_sum_next = wsum_reg;
                    have_next     = 1'b1;
                end
                if (!last_samp)
                begin
                    samp_next  = samp_reg + 2'd1;
                    state_next = ST_SMUL;
                end
                else if (k_inc == '0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                rd_en      = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (z_c < rd_depth_reg)
                    begin
                        wr_color_en  = 1'b1;
                        wr_depth_en  = 1'b1;
                        written_next = written_reg + WCOUNT_W'(1);
                    end
                    advance = 1'b1;
                end
            end
            ST_DRAW_OUT:
            begin
                done_next       = 1'b1;
                wcount_out_next = written_reg;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            samp_next  = '0;
            k_next     = '0;
            have_next  = 1'b0;
            state_next = ST_SMUL;
            if (px_reg == cur_reg.xhi)
            begin
                if (py_reg == cur_reg.yhi)
                begin
                    state_next = ST_DRAW_OUT;
                end
                else
                begin
                    py_next = py_reg + PIX_CW'(1);
                    px_next = cur_reg.xlo;
                end
            end
            else
            begin
                px_next = px_reg + PIX_CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_color_reg  <= 1'b1;
            clr_depth_reg  <= 1'b1;
            report_reg     <= 1'b0;
            init_clear_reg <= 1'b1;
            clr_addr_reg   <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            samp_reg       <= '0;
            k_reg          <= '0;
            have_reg       <= 1'b0;
            written_reg    <= '0;
            done_reg       <= 1'b0;
            color_out_reg  <= '0;
            depth_out_reg  <= '0;
            wcount_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_color_reg  <= clr_color_next;
            clr_depth_reg  <= clr_depth_next;
            report_reg     <= report_next;
            init_clear_reg <= init_clear_next;
            clr_addr_reg   <= clr_addr_next;
            px_reg         <= px_next;
            py_reg         <= py_next;
            samp_reg       <= samp_next;
            k_reg          <= k_next;
            have_reg       <= have_next;
            written_reg    <= written_next;
            done_reg       <= done_next;
            color_out_reg  <= color_out_next;
            depth_out_reg  <= depth_out_next;
            wcount_out_reg <= wcount_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        in_range_reg <= in_range_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        pa_reg       <= pa_c;
        pb_reg       <= pb_c;
        e_reg        <= e_c;
        wz_reg       <= wz_c;
        cov_reg      <= cov_c;
        wsum_reg     <= wsum_c;
        best_num_reg <= best_num_next;
        best_sum_reg <= best_sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_color_en)
        begin
            color_mem[wr_addr] <= wr_color_data;
        end
        if (rd_en)
        begin
            rd_color_reg <= color_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_depth_en)
        begin
            depth_mem[wr_addr] <= wr_depth_data;
        end
        if (rd_en)
        begin
            rd_depth_reg <= depth_mem[rd_addr];
        end
    end

    `TRDT_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `TRDT_ASSERT_SAME(a_div_free, clk, rst_n, div_start, !div_busy)
    `TRDT_ASSERT_SAME(a_init_silent, clk, rst_n, init_clear_reg, !done_reg)

endmodule
